/* design/trrd_pkg.sv */
// trrd_pkg: shared types and constants of the timestamped record run decoder.
// No dependencies; used by every module of the block.
package trrd_pkg;

    localparam int TIMESTAMP_BITS_DEF = 16;
    localparam int RECORD_BYTES       = 4;
    localparam int RESULT_FIFO_DEPTH  = 4;
    localparam int CFG_INDEX_BITS     = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MORE_STATUS  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FINAL_STATUS = 2'd1;

    localparam logic [7:0] MORE_STATUS_RESET  = 8'd0;
    localparam logic [7:0] FINAL_STATUS_RESET = 8'd1;

    localparam logic [1:0] LAST_BYTE_POS = 2'(RECORD_BYTES - 1);

    typedef enum logic [1:0] {
        KIND_RUN     = 2'd0,
        KIND_FINAL   = 2'd1,
        KIND_INVALID = 2'd2,
        KIND_DROPPED = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  sample;
        logic [15:0] run_length;
        logic        last;
        logic        done;
        logic [31:0] total;
    } result_t;

    // up to two result words raised by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

/* design/trrd_record_decoder.sv */
// trrd_record_decoder: record assembly, timestamp arithmetic and decoder state.
// Depends on trrd_pkg.
module trrd_record_decoder #(
    parameter int TIMESTAMP_BITS = trrd_pkg::TIMESTAMP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_fire,
    input  logic [7:0]                          in_byte,
    input  logic                                cfg_we,
    input  logic [trrd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [7:0]                          cfg_data,
    output trrd_pkg::push_t                     push
);

    localparam int TsW = (TIMESTAMP_BITS > 16) ? TIMESTAMP_BITS : 16;

    logic [1:0]                byte_pos_reg, byte_pos_next;
    logic [7:0]                held_reg [0:2];
    logic [7:0]                prev_sample_reg, prev_sample_next;
    logic [TIMESTAMP_BITS-1:0] prev_ts_reg, prev_ts_next;
    logic                      finished_reg, finished_next;
    logic [31:0]               count_reg, count_next;
    logic [7:0]                more_code_reg, final_code_reg;

    logic [TsW-1:0]            ts_wide;
    logic [TIMESTAMP_BITS-1:0] ts, len_raw, len;
    logic [TsW-1:0]            len_wide;
    logic [15:0]               run16;
    logic [32:0]               sum_run, sum_final;
    logic [31:0]               count_run, count_final;
    logic                      is_final, is_more, marker, behind;

    always_comb
    begin
        ts_wide   = TsW'({held_reg[1], held_reg[2]});
        ts        = ts_wide[TIMESTAMP_BITS-1:0];
        is_final  = (in_byte == final_code_reg);
        is_more   = (in_byte == more_code_reg);
        marker    = (prev_ts_reg == '1);
        behind    = (ts < prev_ts_reg);
        len_raw   = marker ? ts : (ts - prev_ts_reg);
        len       = ((len_raw == '0) && (ts == '0)) ? TIMESTAMP_BITS'(1) : len_raw;
        len_wide  = TsW'(len);
        run16     = (len_wide > TsW'(16'hFFFF)) ? 16'hFFFF : len_wide[15:0];
        sum_run   = {1'b0, count_reg} + 33'(len);
        count_run = sum_run[32] ? 32'hFFFF_FFFF : sum_run[31:0];
        sum_final = {1'b0, count_run} + 33'd1;
        count_final = sum_final[32] ? 32'hFFFF_FFFF : sum_final[31:0];
    end

    always_comb
    begin
        byte_pos_next    = byte_pos_reg;
        prev_sample_next = prev_sample_reg;
        prev_ts_next     = prev_ts_reg;
        finished_next    = finished_reg;
        count_next       = count_reg;
        push             = '0;
        push.first.sample = held_reg[0];
        push.first.total  = count_reg;
        push.first.last   = 1'b1;
        push.second       = '0;

        if (in_fire && !finished_reg) begin
            if (byte_pos_reg != trrd_pkg::LAST_BYTE_POS) begin
                byte_pos_next = byte_pos_reg + 2'd1;
            end else begin
                byte_pos_next = '0;
                push.count    = 2'd1;
                if (!is_final && !is_more) begin
                    // bad status ends the capture before any timestamp work
                    finished_next    = 1'b1;
                    push.first.kind  = trrd_pkg::KIND_INVALID;
                    push.first.done  = 1'b1;
                end else if (!marker && behind) begin
                    push.first.kind  = trrd_pkg::KIND_DROPPED;
                end else begin
                    prev_sample_next      = held_reg[0];
                    prev_ts_next          = ts;
                    push.first.kind       = trrd_pkg::KIND_RUN;
                    push.first.sample     = prev_sample_reg;
                    push.first.run_length = run16;
                    push.first.total      = count_run;
                    if (!is_final) begin
                        count_next = count_run;
                    end else begin
                        count_next             = count_final;
                        finished_next          = 1'b1;
                        push.count             = 2'd2;
                        push.first.last        = 1'b0;
                        push.first.done        = 1'b1;
                        push.second.kind       = trrd_pkg::KIND_FINAL;
                        push.second.sample     = held_reg[0];
                        push.second.run_length = 16'd1;
                        push.second.last       = 1'b1;
                        push.second.done       = 1'b1;
                        push.second.total      = count_final;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_pos_reg    <= '0;
            prev_sample_reg <= '0;
            prev_ts_reg     <= '0;
            finished_reg    <= 1'b0;
            count_reg       <= '0;
            more_code_reg   <= trrd_pkg::MORE_STATUS_RESET;
            final_code_reg  <= trrd_pkg::FINAL_STATUS_RESET;
        end else begin
            byte_pos_reg    <= byte_pos_next;
            prev_sample_reg <= prev_sample_next;
            prev_ts_reg     <= prev_ts_next;
            finished_reg    <= finished_next;
            count_reg       <= count_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    trrd_pkg::REG_MORE_STATUS:  more_code_reg  <= cfg_data;
                    trrd_pkg::REG_FINAL_STATUS: final_code_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // header bytes, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire && !finished_reg && (byte_pos_reg != trrd_pkg::LAST_BYTE_POS)) begin
            held_reg[byte_pos_reg] <= in_byte;
        end
    end

    a_finished_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("capture end flag cleared without reset");

    a_pair_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |->
            (push.second.kind == trrd_pkg::KIND_FINAL) && !push.first.last && finished_next)
        else $error("two results without a final record");

    a_results_on_status: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> (byte_pos_reg == trrd_pkg::LAST_BYTE_POS) && in_fire)
        else $error("result raised away from a status byte");

endmodule

/* design/trrd_result_fifo.sv */
// trrd_result_fifo: small result queue taking up to two words a cycle.
// Depends on trrd_pkg.
module trrd_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  trrd_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output trrd_pkg::result_t out_word
);

    localparam int Depth = trrd_pkg::RESULT_FIFO_DEPTH;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    trrd_pkg::result_t mem_reg [0:Depth-1];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next, wr_ptr_plus;
    logic [CntW-1:0]   count_reg, count_next;
    logic              pop;

    assign out_valid   = (count_reg != '0);
    assign pop         = out_valid && out_ready;
    assign room        = (count_reg <= CntW'(Depth - 2));
    assign out_word    = mem_reg[rd_ptr_reg];
    assign wr_ptr_plus = wr_ptr_reg + PtrW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push.count);
        rd_ptr_next = pop ? (rd_ptr_reg + PtrW'(1)) : rd_ptr_reg;
        count_next  = count_reg + CntW'(push.count) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_plus] <= push.second;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> (count_reg <= CntW'(Depth - 2)))
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("result queue count out of range");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push.count == 2'd0)) |=> (count_reg == $past(count_reg) - CntW'(1)))
        else $error("result queue count not reduced on read");

endmodule

/* design/timestamped_record_run_decoder_unit.sv */
// timestamped_record_run_decoder_unit: top level of the record run decoder.
// Depends on trrd_pkg, trrd_record_decoder and trrd_result_fifo.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata[7:0] rx_byte
//  m_axis   | out       | m_axis_tvalid/tready    | tdata, tuser = kind, tlast = last
//  cfg      | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// One byte word is taken per cycle while s_axis_tready is high. Header
// bytes only load the record registers; the status byte is decoded in the cycle it
// is taken and its one or two result words are written straight into a four-word queue.
// With the queue empty, a result word appears on m_axis the cycle after its
// status byte.
// s_axis_tready drops only while the queue holds more than two words,
// so a waiting result never holds up the byte stream at full rate.
// Reset clears record position, stored sample/timestamp and total, and
// reloads the default status codes.
// Once a final or invalid record ends the capture, further bytes are
// swallowed without results until the next reset.
module timestamped_record_run_decoder_unit #(
    parameter int TIMESTAMP_BITS = trrd_pkg::TIMESTAMP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] sample_value, [23:8] run_length, [24] capture_done,
    // [56:25] sample_total, [63:57] zero
    output logic [63:0]                         m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,  // [1:0] result_kind
    output logic                                m_axis_tlast,  // last_of_input
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [trrd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [7:0]                          cfg_data
);

    trrd_pkg::push_t   push;
    trrd_pkg::result_t out_word;
    logic              room;
    logic              in_fire;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = room;
    assign in_fire       = s_axis_tvalid && room;

    trrd_record_decoder #(
        .TIMESTAMP_BITS (TIMESTAMP_BITS)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (s_axis_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    trrd_result_fifo u_results (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    // pack the result word, lowest field first
    assign m_axis_tdata = {7'd0, out_word.total, out_word.done,
                           out_word.run_length, out_word.sample};
    assign m_axis_tuser = out_word.kind;
    assign m_axis_tlast = out_word.last;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for timestamped_record_run_decoder_unit.
// Depends on trrd_pkg and the unit itself; a scoreboard class predicts every
// result word from the accepted byte words and checks m_axis against it.
module testbench;

    localparam int             WATCHDOG_LIMIT    = 3000;
    localparam int             HOLD_OFF_CYCLES   = 300;
    localparam int             SETTLE_CYCLES     = 4;
    localparam int             TAIL_CYCLES       = 20;
    localparam int             RECORDS_PER_PHASE = 58;
    localparam int             TRAILING_BYTES    = 12;
    localparam logic [15:0]    STAMP_OVERFLOW    = 16'hFFFF;
    // index with no register behind it; writes there must change nothing
    localparam logic [trrd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    // Predicts the decoder: record assembly, run lengths, running total and
    // end of capture. Expected words wait in a queue until m_axis shows them.
    class run_decode_scoreboard;
        logic [7:0]        more_code;
        logic [7:0]        final_code;
        logic [1:0]        byte_pos;
        logic [7:0]        held [3];
        logic [7:0]        prev_sample;
        logic [15:0]       prev_stamp;
        bit                finished;
        logic [31:0]       total;
        trrd_pkg::result_t expected_words [$];
        int                errors;
        int                bytes_seen;
        int                words_seen;
        int                kind_seen [4];

        function new();
            more_code   = trrd_pkg::MORE_STATUS_RESET;
            final_code  = trrd_pkg::FINAL_STATUS_RESET;
            byte_pos    = '0;
            foreach (held[i])
                held[i] = '0;
            prev_sample = '0;
            prev_stamp  = '0;
            finished    = 1'b0;
            total       = '0;
            errors      = 0;
            bytes_seen  = 0;
            words_seen  = 0;
            foreach (kind_seen[i])
                kind_seen[i] = 0;
        endfunction

        function void write_reg(logic [trrd_pkg::CFG_INDEX_BITS-1:0] idx, logic [7:0] val);
            if (idx == trrd_pkg::REG_MORE_STATUS)
                more_code = val;
            else if (idx == trrd_pkg::REG_FINAL_STATUS)
                final_code = val;
        endfunction

        // total saturates instead of wrapping
        function void add_samples(logic [31:0] n);
            logic [32:0] sum;
            sum   = {1'b0, total} + {1'b0, n};
            total = sum[32] ? '1 : sum[31:0];
        endfunction

        function void expect_word(trrd_pkg::kind_t k, logic [7:0] s, logic [15:0] len,
                                  logic lst);
            trrd_pkg::result_t w;
            w.kind       = k;
            w.sample     = s;
            w.run_length = len;
            w.last       = lst;
            w.done       = finished;
            w.total      = total;
            expected_words.push_back(w);
        endfunction

        function void take_byte(logic [7:0] b);
            logic [7:0]  sample;
            logic [7:0]  run_sample;
            logic [15:0] stamp;
            logic [15:0] len;
            logic        is_final;
            bytes_seen++;
            if (finished)
                return;
            if (byte_pos != trrd_pkg::LAST_BYTE_POS)
            begin
                held[byte_pos] = b;
                byte_pos       = byte_pos + 2'd1;
                return;
            end
            byte_pos = '0;
            sample   = held[0];
            stamp    = {held[1], held[2]};
            // final wins when both codes match
            is_final = (b == final_code);
            if (!is_final && b != more_code)
            begin
                finished = 1'b1;
                expect_word(trrd_pkg::KIND_INVALID, sample, 16'd0, 1'b1);
                return;
            end
            if (prev_stamp == STAMP_OVERFLOW)
                len = stamp;
            else if (stamp < prev_stamp)
            begin
                // out of order: stored sample, stamp and total untouched
                expect_word(trrd_pkg::KIND_DROPPED, sample, 16'd0, 1'b1);
                return;
            end
            else
                len = stamp - prev_stamp;
            if (len == 16'd0 && stamp == 16'd0)
                len = 16'd1;
            add_samples(32'(len));
            run_sample  = prev_sample;
            prev_sample = sample;
            prev_stamp  = stamp;
            if (!is_final)
            begin
                expect_word(trrd_pkg::KIND_RUN, run_sample, len, 1'b1);
                return;
            end
            finished = 1'b1;
            expect_word(trrd_pkg::KIND_RUN, run_sample, len, 1'b0);
            add_samples(32'd1);
            expect_word(trrd_pkg::KIND_FINAL, sample, 16'd1, 1'b1);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(trrd_pkg::result_t got);
            trrd_pkg::result_t want;
            words_seen++;
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: kind %0d sample %0d length %0d",
                       got.kind, got.sample, got.run_length);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            kind_seen[int'(want.kind)]++;
            compare_field("result_kind",   32'(want.kind),       32'(got.kind));
            compare_field("sample_value",  32'(want.sample),     32'(got.sample));
            compare_field("run_length",    32'(want.run_length), 32'(got.run_length));
            compare_field("last_of_input", 32'(want.last),       32'(got.last));
            compare_field("capture_done",  32'(want.done),       32'(got.done));
            compare_field("sample_total",  want.total,           got.total);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Clock, reset and the unit
    // ---------------------------------------------------------------------
    logic                                clk           = 1'b0;
    logic                                rst_n         = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [7:0]                          s_axis_tdata  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [63:0]                         m_axis_tdata;
    logic [1:0]                          m_axis_tuser;
    logic                                m_axis_tlast;
    logic                                cfg_valid     = 1'b0;
    logic                                cfg_ready;
    logic [trrd_pkg::CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [7:0]                          cfg_data      = '0;

    run_decode_scoreboard sb;

    // stimulus-side view of the codes and the stored stamp (for shaping only)
    logic [7:0]  more_now   = trrd_pkg::MORE_STATUS_RESET;
    logic [7:0]  final_now  = trrd_pkg::FINAL_STATUS_RESET;
    logic [15:0] stim_stamp = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    timestamped_record_run_decoder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Monitor: every input is driven by NBA at the edge, so values read here
    // are the ones the unit saw at this edge. Also the quiet-cycle watchdog.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        trrd_pkg::result_t got;
        logic              moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.take_byte(s_axis_tdata);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind       = trrd_pkg::kind_t'(m_axis_tuser);
                got.sample     = m_axis_tdata[7:0];
                got.run_length = m_axis_tdata[23:8];
                got.done       = m_axis_tdata[24];
                got.total      = m_axis_tdata[56:25];
                got.last       = m_axis_tlast;
                sb.check_word(got);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request so the result
    // queue fills and the unit has to drop s_axis_tready.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------
    // tvalid is left high on return so back-to-back words need no second NBA
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_record(input logic [7:0] sample, input logic [15:0] stamp,
                               input logic [7:0] status);
        send_byte(sample);
        send_byte(stamp[15:8]);
        send_byte(stamp[7:0]);
        send_byte(status);
        if (stamp >= stim_stamp || stim_stamp == STAMP_OVERFLOW)
            stim_stamp = stamp;
    endtask

    // stop sending, let the monitor catch the last edge, wait for all results
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [trrd_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_codes(input logic [7:0] more, input logic [7:0] fin);
        write_reg(trrd_pkg::REG_MORE_STATUS, more);
        write_reg(trrd_pkg::REG_FINAL_STATUS, fin);
        write_reg(REG_SPARE, 8'($urandom));
        cfg_valid <= 1'b0;
        more_now  = more;
        final_now = fin;
    endtask

    function automatic logic [7:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 8'h00;
        else if (roll < 20)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // mostly rising stamps; also repeats, steps back, overflow markers,
    // zero and wild jumps
    function automatic logic [15:0] pick_stamp();
        int unsigned roll;
        int unsigned next;
        roll = $urandom_range(99);
        if (stim_stamp == STAMP_OVERFLOW && roll < 70)
            return 16'($urandom_range(300));
        if (roll < 55)
        begin
            next = stim_stamp + $urandom_range(40);
            return (next > 32'(STAMP_OVERFLOW)) ? STAMP_OVERFLOW : 16'(next);
        end
        else if (roll < 63)
            return stim_stamp;
        else if (roll < 72)
            return (stim_stamp == 16'd0) ? 16'd0 : 16'($urandom_range(stim_stamp - 1));
        else if (roll < 77)
            return STAMP_OVERFLOW;
        else if (roll < 82)
            return 16'd0;
        return 16'($urandom);
    endfunction

    // ---------------------------------------------------------------------
    // Sequence. An invalid or final record ends the capture until reset, and
    // reset happens once, so only the closing record carries either status.
    // ---------------------------------------------------------------------
    initial
    begin
        logic [7:0]  status;
        logic [15:0] stamp;
        int unsigned closing;
        string       closing_name;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset codes: zero run at stamp zero, full-width run,
        // overflow marker then small stamp, step back, equal stamps
        send_record(8'hFF, 16'h0000, more_now);
        send_record(8'h00, 16'hFFFF, more_now);
        send_record(8'hA5, 16'h0080, more_now);
        send_record(8'h5A, 16'h1234, more_now);
        send_record(8'h3C, 16'h1000, more_now);
        send_record(8'hC3, 16'h1234, more_now);
        drain();

        // four idling phases; codes move through both extremes
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_requests++;
                end
                1:
                begin
                    set_codes(8'hFF, 8'h00);
                    send_idle_pct  = 87;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    set_codes(8'h00, 8'hFF);
                    send_idle_pct  = 0;
                    recv_stall_pct = 87;
                end
                default:
                begin
                    status = 8'($urandom);
                    set_codes(status, status ^ 8'($urandom_range(255, 1)));
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            repeat (RECORDS_PER_PHASE)
                send_record(pick_sample(), pick_stamp(), more_now);
            drain();
        end

        // closing record: invalid status, final status, or final with both
        // codes equal; the stamp rises so a final record is not dropped
        closing = $urandom_range(2);
        stamp   = (stim_stamp == STAMP_OVERFLOW) ? 16'($urandom)
                : stim_stamp + 16'($urandom_range(STAMP_OVERFLOW - stim_stamp));
        if (closing == 0)
        begin
            closing_name = "an invalid status";
            do
                status = 8'($urandom);
            while (status == more_now || status == final_now);
        end
        else if (closing == 1)
        begin
            closing_name = "a final record";
            status       = final_now;
        end
        else
        begin
            closing_name = "a final record with both codes equal";
            set_codes(more_now, more_now);
            status = more_now;
        end
        send_record(pick_sample(), stamp, status);
        // bytes after the end of capture must raise nothing
        repeat (TRAILING_BYTES)
            send_byte(8'($urandom));
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d byte words, %0d result words: %0d runs, %0d final,",
                 sb.bytes_seen, sb.words_seen, sb.kind_seen[int'(trrd_pkg::KIND_RUN)],
                 sb.kind_seen[int'(trrd_pkg::KIND_FINAL)]);
        $display("  %0d invalid, %0d dropped; capture closed by %s, sample total %0d",
                 sb.kind_seen[int'(trrd_pkg::KIND_INVALID)],
                 sb.kind_seen[int'(trrd_pkg::KIND_DROPPED)], closing_name, sb.total);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
